@@ rtl/vector_matrix_multiply_core_defines.svh @@
// ----------------------------------------------------------------------------
// Vector matrix multiply core: assertion macros
// Concurrent check macros shared by the core's modules. Defining ASSERT_OFF
// removes every check from the build.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define VECTOR_MATRIX_MULTIPLY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define VMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmm: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define VMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmm: next-cycle check failed");
`else
`define VMM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/vmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector matrix multiply package
// Field widths, opcodes, command queue sizing and shared types.
// ----------------------------------------------------------------------------
package vmm_pkg;

    // Fixed field widths of the item interface.
    localparam int IDX_W = 4;
    localparam int CFG_W = 5;

    // Size register value after reset.
    localparam logic [CFG_W-1:0] CFG_SIZE_RST = 5'd16;

    // Opcodes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // Command queue between front and back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Decoded command handed from the front end to the back end.
    typedef struct packed {
        logic             mat_we;
        logic             vec_we;
        logic             start;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_cmd;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_RESULT
    } t_state;

endpackage

@@ rtl/vmm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vmm_front.sv @@
// ----------------------------------------------------------------------------
// Vector matrix multiply front end
// Accepts items, decodes them into commands and queues them for the back end.
// Items that have no effect are accepted and dropped here.
// ----------------------------------------------------------------------------
module vmm_front #(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]   i_dim,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_opcode,
    input  logic [vmm_pkg::IDX_W-1:0]      i_row_index,
    input  logic [vmm_pkg::IDX_W-1:0]      i_col_index,
    input  logic [DATA_WIDTH-1:0]          i_data_value,
    input  logic                           i_last_element,
    output logic                           o_cmd_valid,
    output vmm_pkg::t_cmd                  o_cmd,
    output logic [DATA_WIDTH-1:0]          o_cmd_data,
    input  logic                           i_cmd_pop
);

    import vmm_pkg::*;

    `include "vector_matrix_multiply_core_defines.svh"

    t_cmd                dec_cmd;
    logic                keep;
    logic                push;
    t_cmd                r_fifo_cmd  [Q_DEPTH];
    logic [DATA_WIDTH-1:0] r_fifo_data [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;

    // Decode the item into store and start actions.
    always_comb begin
        dec_cmd.row    = i_row_index;
        dec_cmd.col    = i_col_index;
        dec_cmd.mat_we = (i_opcode == OP_LOAD) && (int'(i_row_index) < MAX_DIM)
                         && (int'(i_col_index) < MAX_DIM);
        dec_cmd.vec_we = (i_opcode == OP_VECTOR) && (int'(i_row_index) < int'(i_dim));
        dec_cmd.start  = (i_opcode == OP_VECTOR) && i_last_element;
        keep           = dec_cmd.mat_we || dec_cmd.vec_we || dec_cmd.start;
    end

    assign o_stall = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push    = i_valid && !o_stall && keep;

    // Queue occupancy.
    always_comb begin
        case ({push, i_cmd_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_cmd[r_wr_ptr]  <= dec_cmd;
            r_fifo_data[r_wr_ptr] <= i_data_value;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_fifo_cmd[r_rd_ptr];
    assign o_cmd_data  = r_fifo_data[r_rd_ptr];

    // Checks on the queue bookkeeping.
    `VMM_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, (r_count <= Q_CNT_W'(Q_DEPTH)))
    `VMM_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, i_cmd_pop, (r_count != '0))

endmodule

@@ rtl/vmm_back.sv @@
// ----------------------------------------------------------------------------
// Vector matrix multiply back end
// Executes queued commands: matrix and vector stores, and the product of the
// vector with the matrix on one pipelined multiply-accumulate unit.
// ----------------------------------------------------------------------------
module vmm_back #(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]   i_dim,
    input  logic                           i_cmd_valid,
    input  vmm_pkg::t_cmd                  i_cmd,
    input  logic [DATA_WIDTH-1:0]          i_cmd_data,
    output logic                           o_cmd_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vmm_pkg::IDX_W-1:0]      o_out_index,
    output logic [DATA_WIDTH-1:0]          o_out_value,
    output logic                           o_out_last
);

    import vmm_pkg::*;

    `include "vector_matrix_multiply_core_defines.svh"

    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int VEC_AW    = $clog2(MAX_DIM);
    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int DW        = DATA_WIDTH;
    localparam int ACC_W     = (2 * DW + 8 > 64) ? 64 : 2 * DW + 8;
    localparam int FRAC      = DW - 4;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   =
        ACC_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

    t_state              r_state, n_state;
    logic [VEC_AW-1:0]   r_p, n_p;
    logic [VEC_AW-1:0]   r_q, n_q;
    logic [MAT_AW-1:0]   r_mat_addr, n_mat_addr;
    logic [VEC_AW-1:0]   last_idx;
    logic                issue;
    logic                load_out;
    logic                out_take;
    logic                out_free;

    logic                mat_we;
    logic                vec_we;
    logic [MAT_AW-1:0]   mat_waddr;
    logic [DW-1:0]       mat_rdata;
    logic [DW-1:0]       vec_rdata;

    logic                r_s1_valid, r_s1_first, r_s1_last;
    logic                r_s2_valid, r_s2_first, r_s2_last;
    logic signed [2*DW-1:0] r_prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] r_acc;
    logic                r_acc_done;

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_shift;
    logic [DW-1:0]       sat_val;

    logic                r_o_valid;
    logic [IDX_W-1:0]    r_o_index;
    logic [DW-1:0]       r_o_value;
    logic                r_o_last;

    assign last_idx = VEC_AW'(i_dim - CNT_W'(1));
    assign out_take = r_o_valid && !i_stall;
    assign out_free = !r_o_valid || out_take;

    // Sequencer: next state, counters and control strobes.
    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_q        = r_q;
        n_mat_addr = r_mat_addr;
        issue      = 1'b0;
        load_out   = 1'b0;
        o_cmd_pop  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.start) begin
                        n_p        = '0;
                        n_q        = '0;
                        n_mat_addr = '0;
                        n_state    = S_MAC;
                    end
                end
            end
            S_MAC: begin
                issue      = 1'b1;
                n_q        = r_q + VEC_AW'(1);
                n_mat_addr = r_mat_addr + MAT_AW'(MAX_DIM);
                if (r_q == last_idx) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (r_acc_done && out_free) begin
                    load_out = 1'b1;
                    if (r_p == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_p        = r_p + VEC_AW'(1);
                        n_q        = '0;
                        n_mat_addr = MAT_AW'(r_p) + MAT_AW'(1);
                        n_state    = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p        <= '0;
            r_q        <= '0;
            r_mat_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_p        <= n_p;
            r_q        <= n_q;
            r_mat_addr <= n_mat_addr;
        end
    end

    // Store ports for matrix entries and vector elements.
    assign mat_we    = o_cmd_pop && i_cmd.mat_we;
    assign vec_we    = o_cmd_pop && i_cmd.vec_we;
    assign mat_waddr = MAT_AW'(int'(i_cmd.row) * MAX_DIM + int'(i_cmd.col));

    vmm_ram #(
        .WIDTH (DW),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (i_cmd_data),
        .i_raddr (r_mat_addr),
        .o_rdata (mat_rdata)
    );

    vmm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (VEC_AW'(i_cmd.row)),
        .i_wdata (i_cmd_data),
        .i_raddr (r_q),
        .o_rdata (vec_rdata)
    );

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid && r_s2_last) begin
                r_acc_done <= 1'b1;
            end else if (load_out) begin
                r_acc_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_q == '0);
        r_s1_last  <= (r_q == last_idx);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= $signed(vec_rdata) * $signed(mat_rdata);
        if (r_s2_valid) begin
            r_acc <= r_s2_first ? prod_ext : r_acc + prod_ext;
        end
    end

    // Round half up to the output scale and saturate.
    always_comb begin
        rnd_sum   = r_acc + RND_HALF;
        rnd_shift = rnd_sum >>> FRAC;
        if (rnd_shift > SAT_HI) begin
            sat_val = DW'(SAT_HI);
        end else if (rnd_shift < SAT_LO) begin
            sat_val = DW'(SAT_LO);
        end else begin
            sat_val = DW'(rnd_shift);
        end
    end

    // Output register; a new result loads when it is empty or as the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (out_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_index <= IDX_W'(r_p);
            r_o_value <= sat_val;
            r_o_last  <= (r_p == last_idx);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_index = r_o_index;
    assign o_out_value = r_o_value;
    assign o_out_last  = r_o_last;

    // Checks on the sequencer and the accumulator hand-off.
    `VMM_ASSERT_NOW(a_pop_when_idle, i_clk, i_rst_n, o_cmd_pop, (r_state == S_IDLE))
    `VMM_ASSERT_NOW(a_done_in_result, i_clk, i_rst_n, r_acc_done, (r_state == S_RESULT))
    `VMM_ASSERT_NEXT(a_last_sets_done, i_clk, i_rst_n, (r_s2_valid && r_s2_last), r_acc_done)

endmodule

@@ rtl/vector_matrix_multiply_core.sv @@
// ----------------------------------------------------------------------------
// Vector matrix multiply core
// Input channel: matrix loads (opcode 0) and vector elements (opcode 1),
// handshake i_valid / o_stall. Output channel: one result item per column p,
// handshake o_valid / i_stall, in order p = 0 .. n-1, o_out_last on the final.
// i_cfg_we / i_cfg_data write the size register (n, reset 16); the user is to
// write it only while idle, as the block itself does not enforce this.
// Loads and vector elements are executed by the back end; a four-entry command
// queue lets the input side run ahead of the back end.
// A vector element marked last starts the product; each result needs n
// multiply-accumulates on the single MAC unit and its matrix RAM read port,
// which then pass through the read, multiply and accumulate pipeline.
// A stalled result holds in the output register; the core then pauses and
// the queue fills, after which o_stall rises.
// Reset is synchronous and clears the queue, the sequencer and the output
// valid; matrix and vector contents are undefined until written.
// ----------------------------------------------------------------------------
module vector_matrix_multiply_core #(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vmm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_opcode,
    input  logic [vmm_pkg::IDX_W-1:0]      i_row_index,
    input  logic [vmm_pkg::IDX_W-1:0]      i_col_index,
    input  logic [DATA_WIDTH-1:0]          i_data_value,
    input  logic                           i_last_element,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vmm_pkg::IDX_W-1:0]      o_out_index,
    output logic [DATA_WIDTH-1:0]          o_out_value,
    output logic                           o_out_last
);

    import vmm_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0]    r_size;
    logic [CNT_W-1:0]    dim;
    logic                cmd_valid;
    t_cmd                cmd;
    logic [DATA_WIDTH-1:0] cmd_data;
    logic                cmd_pop;

    // Size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RST;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    // Working dimension: zero acts as one, large values clamp to MAX_DIM.
    always_comb begin
        if (int'(r_size) > MAX_DIM) begin
            dim = CNT_W'(MAX_DIM);
        end else if (r_size == '0) begin
            dim = CNT_W'(1);
        end else begin
            dim = CNT_W'(r_size);
        end
    end

    vmm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dim          (dim),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_data_value   (i_data_value),
        .i_last_element (i_last_element),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .o_cmd_data     (cmd_data),
        .i_cmd_pop      (cmd_pop)
    );

    vmm_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim       (dim),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_cmd_data  (cmd_data),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule
